// ===== hw/rtl/salc_pkg.sv =====
// Shared definitions for the set-associative LRU cache tag store.
// Command codes and the result record; no dependencies.
package salc_pkg;

  localparam int ADDR_W = 32;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_INVAL = 2'd2;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [ADDR_W-1:0] victim_address;
    logic              victim_dirty;
    logic              found;
    logic              was_dirty;
  } result_t;

endpackage

// ===== hw/rtl/salc_set_update.sv =====
// Lookup, replacement and LRU rank update for one set read from the tag store.
// Depends on salc_pkg for command codes and the result record.
module salc_set_update import salc_pkg::*; #(
  parameter int NUM_WAYS  = 4,
  parameter int WAY_W     = 2,
  parameter int RANK_W    = 2,
  parameter int TAG_SHIFT = 13
) (
  input  logic [1:0]                           command,
  input  logic [ADDR_W-1:0]                    address,
  input  logic                                 write_allocate,
  input  logic [NUM_WAYS-1:0][ADDR_W-1:0]      rd_address,
  input  logic [NUM_WAYS-1:0]                  rd_valid,
  input  logic [NUM_WAYS-1:0]                  rd_dirty,
  input  logic [NUM_WAYS-1:0][RANK_W-1:0]      rd_rank,
  output logic [NUM_WAYS-1:0]                  wr_valid,
  output logic [NUM_WAYS-1:0]                  wr_dirty,
  output logic [NUM_WAYS-1:0][RANK_W-1:0]      wr_rank,
  output logic                                 addr_we,
  output logic [WAY_W-1:0]                     addr_way,
  output result_t                              result
);

  localparam logic [RANK_W-1:0] TOP_RANK = RANK_W'(NUM_WAYS - 1);

  logic [NUM_WAYS-1:0] match;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim_way;
  logic                do_touch;
  logic [WAY_W-1:0]    touch_way;
  logic [RANK_W-1:0]   old_rank;
  logic                do_fill;

  always_comb begin
    hit_way    = '0;
    victim_way = '0;
    // scan downward so the lowest-numbered way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      match[w] = rd_valid[w] && ((rd_address[w] >> TAG_SHIFT) == (address >> TAG_SHIFT));
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (rd_rank[w] == '0) begin
        victim_way = WAY_W'(w);
      end
    end
    hit_any = |match;
  end

  always_comb begin
    result    = '0;
    wr_valid  = rd_valid;
    wr_dirty  = rd_dirty;
    do_touch  = 1'b0;
    do_fill   = 1'b0;
    touch_way = hit_way;
    case (command)
      CMD_READ, CMD_WRITE: begin
        if (hit_any) begin
          do_touch   = 1'b1;
          result.hit = 1'b1;
          if (command == CMD_WRITE) begin
            wr_dirty[hit_way] = 1'b1;
          end
        end else if (command == CMD_READ || write_allocate) begin
          do_fill   = 1'b1;
          do_touch  = 1'b1;
          touch_way = victim_way;
          if (rd_valid[victim_way]) begin
            result.evicted        = 1'b1;
            result.victim_address = rd_address[victim_way];
            result.victim_dirty   = rd_dirty[victim_way];
          end
          wr_valid[victim_way] = 1'b1;
          wr_dirty[victim_way] = (command == CMD_WRITE);
        end
      end
      CMD_INVAL: begin
        if (hit_any) begin
          wr_valid[hit_way] = 1'b0;
          result.found      = 1'b1;
          result.was_dirty  = rd_dirty[hit_way];
        end
      end
      default: begin
      end
    endcase
  end

  // touched way goes to the top, ways ranked above its old rank drop by one
  always_comb begin
    old_rank = rd_rank[touch_way];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!do_touch) begin
        wr_rank[w] = rd_rank[w];
      end else if (WAY_W'(w) == touch_way) begin
        wr_rank[w] = TOP_RANK;
      end else if (rd_rank[w] > old_rank) begin
        wr_rank[w] = rd_rank[w] - 1'b1;
      end else begin
        wr_rank[w] = rd_rank[w];
      end
    end
  end

  assign addr_we  = do_fill;
  assign addr_way = victim_way;

endmodule

// ===== hw/rtl/set_assoc_lru_cache_tags.sv =====
// Top level of the write-back set-associative cache tag store with LRU ranks.
// Depends on salc_pkg and salc_set_update.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   request  | in_valid / in_ready    | command, address
//   result   | out_valid / out_ready  | hit, evicted, victim_address, victim_dirty,
//            |                        | found, was_dirty
//   config   | cfg_we                 | cfg_wdata (write_allocate)
//
// For each request the set's row is read from the synchronous state and
// address memories, then updated and written back; the next request is taken the
// cycle after the write-back, so the same row is never read before it is written.
// After reset a clearing pass zeroes the state memory, one set per cycle, covering
// 2^(CACHE_SIZE_LOG2 - BLOCK_SIZE_LOG2 - WAYS_LOG2) sets (256 at the defaults).
// A result not yet taken holds the update in the lookup state; a new request is
// taken while a finished result waits in the output register.
module set_assoc_lru_cache_tags import salc_pkg::*; #(
  parameter int CACHE_SIZE_LOG2 = 15,
  parameter int BLOCK_SIZE_LOG2 = 5,
  parameter int WAYS_LOG2       = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic              evicted,
  output logic [ADDR_W-1:0] victim_address,
  output logic              victim_dirty,
  output logic              found,
  output logic              was_dirty,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int SET_BITS_RAW = CACHE_SIZE_LOG2 - BLOCK_SIZE_LOG2 - WAYS_LOG2;
  localparam int SET_BITS     = (SET_BITS_RAW > 0) ? SET_BITS_RAW : 0;
  localparam int NUM_SETS     = 1 << SET_BITS;
  localparam int SET_IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int NUM_WAYS     = 1 << WAYS_LOG2;
  localparam int WAY_W        = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
  localparam int RANK_W       = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
  localparam int TAG_SHIFT    = SET_BITS + BLOCK_SIZE_LOG2;
  localparam int ST_W         = NUM_WAYS * (2 + RANK_W);

  localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(NUM_SETS - 1);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [SET_IDX_W-1:0] clr_cnt;
  logic                 write_allocate;

  logic [1:0]           req_command;
  logic [ADDR_W-1:0]    req_address;
  logic [SET_IDX_W-1:0] req_set;
  logic [SET_IDX_W-1:0] in_set;

  logic [ST_W-1:0]                  st_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][ADDR_W-1:0]  addr_mem [NUM_SETS];
  logic [ST_W-1:0]                  st_rd;
  logic [NUM_WAYS-1:0][ADDR_W-1:0]  addr_rd;

  logic                  accept;
  logic                  fire;
  logic                  clearing;
  logic                  st_we;
  logic [SET_IDX_W-1:0]  st_widx;
  logic [ST_W-1:0]       st_wdata;

  logic [NUM_WAYS-1:0]             rd_valid;
  logic [NUM_WAYS-1:0]             rd_dirty;
  logic [NUM_WAYS-1:0][RANK_W-1:0] rd_rank;
  logic [NUM_WAYS-1:0]             wr_valid;
  logic [NUM_WAYS-1:0]             wr_dirty;
  logic [NUM_WAYS-1:0][RANK_W-1:0] wr_rank;
  logic                            addr_we;
  logic [WAY_W-1:0]                addr_way;
  result_t                         upd_result;
  result_t                         out_result;

  assign in_set   = (SET_BITS > 0) ? address[BLOCK_SIZE_LOG2 +: SET_IDX_W] : '0;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign clearing = (state == S_CLEAR);
  // hold the update until the output register can take its result
  assign fire     = (state == S_LOOKUP) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == LAST_SET) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      write_allocate <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        write_allocate <= cfg_wdata;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_command <= command;
      req_address <= address;
      req_set     <= in_set;
    end
    if (fire) begin
      out_result <= upd_result;
    end
  end

  // state memory: valid, dirty and rank of every way of a set in one row
  assign st_we    = clearing || fire;
  assign st_widx  = clearing ? clr_cnt : req_set;
  assign st_wdata = clearing ? '0 : {wr_rank, wr_dirty, wr_valid};

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_widx] <= st_wdata;
    end
    if (accept) begin
      st_rd <= st_mem[in_set];
    end
  end

  // address memory: written per way on a fill, read as a whole row
  always_ff @(posedge clk) begin
    if (fire && addr_we) begin
      addr_mem[req_set][addr_way] <= req_address;
    end
    if (accept) begin
      addr_rd <= addr_mem[in_set];
    end
  end

  assign rd_valid = st_rd[NUM_WAYS-1:0];
  assign rd_dirty = st_rd[2*NUM_WAYS-1:NUM_WAYS];
  assign rd_rank  = st_rd[ST_W-1:2*NUM_WAYS];

  salc_set_update #(
    .NUM_WAYS  (NUM_WAYS),
    .WAY_W     (WAY_W),
    .RANK_W    (RANK_W),
    .TAG_SHIFT (TAG_SHIFT)
  ) u_update (
    .command        (req_command),
    .address        (req_address),
    .write_allocate (write_allocate),
    .rd_address     (addr_rd),
    .rd_valid       (rd_valid),
    .rd_dirty       (rd_dirty),
    .rd_rank        (rd_rank),
    .wr_valid       (wr_valid),
    .wr_dirty       (wr_dirty),
    .wr_rank        (wr_rank),
    .addr_we        (addr_we),
    .addr_way       (addr_way),
    .result         (upd_result)
  );

  assign hit            = out_result.hit;
  assign evicted        = out_result.evicted;
  assign victim_address = out_result.victim_address;
  assign victim_dirty   = out_result.victim_dirty;
  assign found          = out_result.found;
  assign was_dirty      = out_result.was_dirty;

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOKUP) && !in_ready)
    else $error("request accepted without moving to lookup");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("set update did not produce a result");

  a_hit_excludes_evict: assert property (@(posedge clk) disable iff (rst)
    fire |-> !(upd_result.hit && (upd_result.evicted || upd_result.found)))
    else $error("hit reported together with eviction or invalidate");

  a_no_update_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !fire && !accept)
    else $error("access during clearing pass");

endmodule

// ===== sim/set_assoc_lru_cache_tags_tb.sv =====
// Self-checking testbench for the set-associative LRU cache tag store.
// Needs salc_pkg and set_assoc_lru_cache_tags; predicts every result from its own
// copy of the tag, valid, dirty and rank state.
`timescale 1ns / 100ps

module set_assoc_lru_cache_tags_tb;
  import salc_pkg::*;

  localparam int BLOCK_LOG2 = 5;
  localparam int SET_BITS   = 8;
  localparam int WAY_COUNT  = 4;
  localparam int LINE_COUNT = (1 << SET_BITS) * WAY_COUNT;
  localparam int TAG_LSB    = SET_BITS + BLOCK_LOG2;
  localparam logic [1:0] TOP_RANK   = 2'd3;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = CMD_READ;
  logic [ADDR_W-1:0] address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic              evicted;
  logic [ADDR_W-1:0] victim_address;
  logic              victim_dirty;
  logic              found;
  logic              was_dirty;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  // shadow of the cache state
  logic [ADDR_W-1:0] line_tag_addr [LINE_COUNT];
  logic              line_is_valid [LINE_COUNT];
  logic              line_is_dirty [LINE_COUNT];
  logic [1:0]        line_rank [LINE_COUNT];
  logic              alloc_on_write;

  result_t    expected_results [$];
  int         mismatches = 0;
  logic       no_idle = 1'b0;
  logic [7:0]  hot_sets [4];
  logic [18:0] hot_tags [7];

  set_assoc_lru_cache_tags dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .evicted        (evicted),
    .victim_address (victim_address),
    .victim_dirty   (victim_dirty),
    .found          (found),
    .was_dirty      (was_dirty),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Move the touched way to the top rank and shift down the ways above its old rank.
  function automatic void promote_way(int base, int way);
    logic [1:0] old_rank;
    old_rank = line_rank[base + way];
    line_rank[base + way] = TOP_RANK;
    for (int w = 0; w < WAY_COUNT; w++)
      if (w != way && line_rank[base + w] > old_rank) line_rank[base + w]--;
  endfunction

  function automatic result_t predict_access(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
    result_t res;
    int      base;
    int      way;
    int      victim;
    res = '0;
    base = int'(addr[TAG_LSB-1:BLOCK_LOG2]) * WAY_COUNT;
    way = WAY_COUNT;
    for (int w = WAY_COUNT - 1; w >= 0; w--)
      if (line_is_valid[base + w] && line_tag_addr[base + w][ADDR_W-1:TAG_LSB] ==
          addr[ADDR_W-1:TAG_LSB]) way = w;
    if (cmd == CMD_INVAL) begin
      if (way < WAY_COUNT) begin
        res.found = 1'b1;
        res.was_dirty = line_is_dirty[base + way];
        line_is_valid[base + way] = 1'b0;
      end
    end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (way < WAY_COUNT) begin
        res.hit = 1'b1;
        promote_way(base, way);
        if (cmd == CMD_WRITE) line_is_dirty[base + way] = 1'b1;
      end else if (cmd == CMD_READ || alloc_on_write) begin
        // lowest way of rank zero, way 0 if none
        victim = 0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
          if (line_rank[base + w] == 2'd0) victim = w;
        if (line_is_valid[base + victim]) begin
          res.evicted = 1'b1;
          res.victim_address = line_tag_addr[base + victim];
          res.victim_dirty = line_is_dirty[base + victim];
        end
        line_tag_addr[base + victim] = addr;
        line_is_valid[base + victim] = 1'b1;
        line_is_dirty[base + victim] = (cmd == CMD_WRITE);
        promote_way(base, victim);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    if (mismatches < 40)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", '0, '0);
      end else begin
        want = expected_results.pop_front();
        if (hit !== want.hit)
          report_mismatch("hit", ADDR_W'(hit), ADDR_W'(want.hit));
        if (evicted !== want.evicted)
          report_mismatch("evicted", ADDR_W'(evicted), ADDR_W'(want.evicted));
        if (victim_address !== want.victim_address)
          report_mismatch("victim_address", victim_address, want.victim_address);
        if (victim_dirty !== want.victim_dirty)
          report_mismatch("victim_dirty", ADDR_W'(victim_dirty),
                          ADDR_W'(want.victim_dirty));
        if (found !== want.found)
          report_mismatch("found", ADDR_W'(found), ADDR_W'(want.found));
        if (was_dirty !== want.was_dirty)
          report_mismatch("was_dirty", ADDR_W'(was_dirty), ADDR_W'(want.was_dirty));
      end
    end
  end

  // Leaves valid high on return so back-to-back requests need no gap.
  task automatic send_request(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_access(cmd, addr));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_alloc_cfg(logic value);
    wait_results_done();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    alloc_on_write = value;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] addr;
    addr = $urandom;
    // mostly a few busy sets with more tags than ways, so hits and evictions mix
    if ($urandom_range(9) != 0) begin
      addr[TAG_LSB-1:BLOCK_LOG2] = hot_sets[$urandom_range(3)];
      addr[ADDR_W-1:TAG_LSB] = hot_tags[$urandom_range(6)];
    end
    return addr;
  endfunction

  task automatic test_fill_hit_evict();
    write_alloc_cfg(1'b1);
    send_request(CMD_READ,   32'h0000_0000);
    send_request(CMD_READ,   32'h0000_001F);
    send_request(CMD_WRITE,  32'h0000_0004);
    send_request(CMD_READ,   32'h0000_2000);
    send_request(CMD_WRITE,  32'h0000_4000);
    send_request(CMD_READ,   32'h0000_6000);
    send_request(CMD_READ,   32'h0000_8000);
    send_request(CMD_INVAL,  32'h0000_4010);
    send_request(CMD_INVAL,  32'h0000_4000);
    send_request(CMD_READ,   32'h0000_4000);
    send_request(CMD_UNUSED, 32'h0000_2000);
    send_request(CMD_READ,   32'hFFFF_FFFF);
    send_request(CMD_WRITE,  32'hFFFF_FFFF);
    send_request(CMD_INVAL,  32'hFFFF_FFE0);
    send_request(CMD_WRITE,  32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    send_request(CMD_READ,   32'h0000_2000);
    wait_results_done();
  endtask

  task automatic test_write_around();
    write_alloc_cfg(1'b0);
    send_request(CMD_WRITE, 32'h1234_5678);
    send_request(CMD_READ,  32'h1234_5678);
    send_request(CMD_WRITE, 32'h1234_5660);
    send_request(CMD_WRITE, 32'h8000_0000);
    send_request(CMD_INVAL, 32'h1234_5678);
    send_request(CMD_INVAL, 32'h1234_5678);
    wait_results_done();
  endtask

  task automatic test_random_traffic(int count, logic alloc, logic with_steady);
    int pick;
    logic [1:0] cmd;
    write_alloc_cfg(alloc);
    foreach (hot_sets[i]) hot_sets[i] = 8'($urandom);
    foreach (hot_tags[i]) hot_tags[i] = 19'($urandom);
    for (int n = 0; n < count; n++) begin
      if (with_steady && n == count / 3) no_idle <= 1'b1;
      if (with_steady && n == count / 3 + 80) no_idle <= 1'b0;
      // hold off until the pipeline is empty, then resume
      if (n == count / 2) wait_results_done();
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_READ;
      else if (pick < 80) cmd = CMD_WRITE;
      else if (pick < 95) cmd = CMD_INVAL;
      else cmd = CMD_UNUSED;
      send_request(cmd, pick_address());
    end
    wait_results_done();
  endtask

  initial begin
    foreach (line_is_valid[i]) begin
      line_is_valid[i] = 1'b0;
      line_is_dirty[i] = 1'b0;
      line_rank[i] = 2'd0;
    end
    alloc_on_write = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_hit_evict();
    test_write_around();
    test_random_traffic(180, 1'b1, 1'b1);
    test_random_traffic(170, 1'b0, 1'b0);
    test_random_traffic(180, 1'b1, 1'b0);
    test_random_traffic(170, 1'b0, 1'b1);

    wait_results_done();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/salc_pkg.sv
hw/rtl/salc_set_update.sv
hw/rtl/set_assoc_lru_cache_tags.sv
sim/set_assoc_lru_cache_tags_tb.sv
